// ----- sv/shared_mapping_tracker_table_top_defines.svh -----
// Assertion macros for the shared mapping tracker table.
// Used by the modules that assert; expect signals clk and rst in scope.
`ifndef SHARED_MAPPING_TRACKER_TABLE_TOP_DEFINES_SVH
`define SHARED_MAPPING_TRACKER_TABLE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SMT_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequence in the cycle after a trigger.
`define SMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/smt_pkg.sv -----
// Types, codes and constants of the shared mapping tracker table.
// No dependencies; imported by every module of the block but smt_ram.
package smt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PAGE_SHIFT    = 12;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int PAGE_W        = 20;

  typedef enum logic [1:0] {
    ACT_TRACK  = 2'd0,
    ACT_REVOKE = 2'd1,
    ACT_FORGET = 2'd2,
    ACT_UNMAP  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] peer;
    logic [31:0] virt;
    logic [31:0] phys;
    logic [31:0] map_len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    status_t     status;
    logic [5:0]  slot_index;
    logic        unmap_valid;
    logic [15:0] unmap_peer;
    logic [31:0] unmap_virt_addr;
    logic [19:0] unmap_page_count;
    logic [6:0]  cleared_count;
    logic        last;
  } res_t;

  function automatic logic [PAGE_W-1:0] pages_of(input logic [31:0] nbytes);
    logic [31:0] sh;
    sh = nbytes >> PAGE_SHIFT;
    return sh[PAGE_W-1:0];
  endfunction

endpackage

// ----- sv/smt_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies; holds the table entries.
module smt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/smt_out.sv -----
// Output register of the result channel.
// Depends on smt_pkg for the result word type.
module smt_out import smt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t res,
  output logic out_free,
  output logic rsp_valid,
  input  logic rsp_ready,
  output res_t res_q
);

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && out_free) begin
      res_q <= res;
    end
  end

endmodule

// ----- sv/smt_scan.sv -----
// Walk controller: latches a request word, sweeps the table memory one entry
// a cycle unless stalled, builds result words. Needs smt_pkg and defines header.
`include "shared_mapping_tracker_table_top_defines.svh"

module smt_scan import smt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [1:0]       action,
  input  logic [15:0]      owner_id,
  input  logic [15:0]      peer_id,
  input  logic [31:0]      peer_virt_addr,
  input  logic [31:0]      phys_addr,
  input  logic [31:0]      map_bytes,
  input  entry_t           rdata,
  output logic [IDX_W-1:0] raddr,
  output logic             we,
  output logic [IDX_W-1:0] waddr,
  output entry_t           wdata,
  input  logic             out_free,
  output logic             push,
  output res_t             res
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                   state, state_next;
  logic [TABLE_ENTRIES-1:0] used, used_next;
  logic                     pend_valid, pend_valid_next;
  logic [IDX_W-1:0]         idx, idx_next;
  act_t                     act, act_next;
  logic [15:0]              owner, owner_next;
  logic [15:0]              peer, peer_next;
  logic [31:0]              virt, virt_next;
  logic [31:0]              phys, phys_next;
  logic [31:0]              map_len, map_len_next;
  logic                     bad, bad_next;
  logic                     match_found, match_found_next;
  logic [IDX_W-1:0]         match_idx, match_idx_next;
  logic                     free_found, free_found_next;
  logic [IDX_W-1:0]         free_idx, free_idx_next;
  logic [15:0]              pend_peer, pend_peer_next;
  logic [31:0]              pend_virt, pend_virt_next;
  logic [PAGE_W-1:0]        pend_pages, pend_pages_next;
  logic [CNT_W-1:0]         cnt, cnt_next;

  logic at_end, cur_used, hit_trk, hit_own, hit_peer, hit_unm, stall;

  assign at_end   = (idx == IDX_W'(TABLE_ENTRIES - 1));
  assign cur_used = used[idx];
  assign hit_peer = cur_used && (rdata.peer == peer);
  assign hit_own  = cur_used && (rdata.owner == owner);
  assign hit_trk  = hit_peer && (rdata.virt == virt) && (rdata.phys == phys);
  assign hit_unm  = hit_peer && (rdata.virt == virt);
  assign stall    = (state == S_SCAN) && (act == ACT_REVOKE) && hit_own &&
                    pend_valid && !out_free;

  assign req_ready = (state == S_IDLE);
  assign raddr     = idx_next;
  assign wdata     = '{owner: owner, peer: peer, virt: virt, phys: phys, map_len: map_len};

  always_comb begin
    state_next       = state;
    used_next        = used;
    pend_valid_next  = pend_valid;
    idx_next         = idx;
    act_next         = act;
    owner_next       = owner;
    peer_next        = peer;
    virt_next        = virt;
    phys_next        = phys;
    map_len_next     = map_len;
    bad_next         = bad;
    match_found_next = match_found;
    match_idx_next   = match_idx;
    free_found_next  = free_found;
    free_idx_next    = free_idx;
    pend_peer_next   = pend_peer;
    pend_virt_next   = pend_virt;
    pend_pages_next  = pend_pages;
    cnt_next         = cnt;
    push             = 1'b0;
    res              = '0;
    we               = 1'b0;
    waddr            = match_idx;

    case (state)
      S_IDLE: begin
        idx_next = '0;
        if (req_valid) begin
          act_next         = act_t'(action);
          owner_next       = owner_id;
          peer_next        = peer_id;
          virt_next        = peer_virt_addr;
          phys_next        = phys_addr;
          map_len_next     = map_bytes;
          match_found_next = 1'b0;
          free_found_next  = 1'b0;
          pend_valid_next  = 1'b0;
          cnt_next         = '0;
          case (act_t'(action))
            ACT_TRACK:  bad_next = (owner_id == 16'd0) || (peer_id == 16'd0);
            ACT_REVOKE: bad_next = (owner_id == 16'd0);
            default:    bad_next = (peer_id == 16'd0);
          endcase
          state_next = bad_next ? S_DONE : S_SCAN;
        end
      end

      S_SCAN: begin
        if (!stall) begin
          case (act)
            ACT_TRACK: begin
              if (hit_trk && !match_found) begin
                match_found_next = 1'b1;
                match_idx_next   = idx;
              end
              if (!cur_used && !free_found) begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
              end
            end
            ACT_REVOKE: begin
              if (hit_own) begin
                // flush the previous hit; it is not the last one
                if (pend_valid) begin
                  push                 = 1'b1;
                  res.status           = ST_OK;
                  res.unmap_valid      = 1'b1;
                  res.unmap_peer       = pend_peer;
                  res.unmap_virt_addr  = pend_virt;
                  res.unmap_page_count = pend_pages;
                end
                pend_valid_next = 1'b1;
                pend_peer_next  = rdata.peer;
                pend_virt_next  = rdata.virt;
                pend_pages_next = pages_of(rdata.map_len);
                used_next[idx]  = 1'b0;
              end
            end
            ACT_FORGET: begin
              if (hit_peer) begin
                used_next[idx] = 1'b0;
                cnt_next       = cnt + CNT_W'(1);
              end
            end
            default: begin
              if (hit_unm && !pend_valid) begin
                pend_valid_next = 1'b1;
                pend_peer_next  = rdata.peer;
                pend_virt_next  = rdata.virt;
                pend_pages_next = pages_of(rdata.map_len);
                used_next[idx]  = 1'b0;
              end
            end
          endcase
          if (at_end) begin
            state_next = S_DONE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          push            = 1'b1;
          res.last        = 1'b1;
          state_next      = S_IDLE;
          idx_next        = '0;
          pend_valid_next = 1'b0;
          if (bad) begin
            res.status = ST_BAD_ID;
          end else begin
            case (act)
              ACT_TRACK: begin
                if (match_found) begin
                  we             = 1'b1;
                  waddr          = match_idx;
                  res.status     = ST_OK;
                  res.slot_index = 6'(match_idx);
                end else if (free_found) begin
                  we                  = 1'b1;
                  waddr               = free_idx;
                  used_next[free_idx] = 1'b1;
                  res.status          = ST_OK;
                  res.slot_index      = 6'(free_idx);
                end else begin
                  res.status = ST_FULL;
                end
              end
              ACT_REVOKE: begin
                res.status = ST_OK;
                if (pend_valid) begin
                  res.unmap_valid      = 1'b1;
                  res.unmap_peer       = pend_peer;
                  res.unmap_virt_addr  = pend_virt;
                  res.unmap_page_count = pend_pages;
                end
              end
              ACT_FORGET: begin
                res.status        = ST_OK;
                res.cleared_count = 7'(cnt);
              end
              default: begin
                if (pend_valid) begin
                  res.status           = ST_OK;
                  res.unmap_valid      = 1'b1;
                  res.unmap_peer       = pend_peer;
                  res.unmap_virt_addr  = pend_virt;
                  res.unmap_page_count = pend_pages;
                end else begin
                  res.status = ST_NOT_FOUND;
                end
              end
            endcase
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      pend_valid <= 1'b0;
      idx        <= '0;
    end else begin
      state      <= state_next;
      used       <= used_next;
      pend_valid <= pend_valid_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    act         <= act_next;
    owner       <= owner_next;
    peer        <= peer_next;
    virt        <= virt_next;
    phys        <= phys_next;
    map_len     <= map_len_next;
    bad         <= bad_next;
    match_found <= match_found_next;
    match_idx   <= match_idx_next;
    free_found  <= free_found_next;
    free_idx    <= free_idx_next;
    pend_peer   <= pend_peer_next;
    pend_virt   <= pend_virt_next;
    pend_pages  <= pend_pages_next;
    cnt         <= cnt_next;
  end

  `SMT_ASSERT_NOW(a_push_free, !push || out_free, "result word pushed into a full output")
  `SMT_ASSERT_NOW(a_idle_no_pend, (state != S_IDLE) || !pend_valid, "held hit left over in idle")
  `SMT_ASSERT_NOW(a_write_done, !we || ((state == S_DONE) && (act == ACT_TRACK)), "table write outside track finish")
  `SMT_ASSERT_NEXT(a_stall_hold, stall, $stable(idx) && (state == S_SCAN), "walk moved during stall")
  `SMT_ASSERT_NEXT(a_done_idle, (state == S_DONE) && out_free, state == S_IDLE, "finish did not return to idle")

endmodule

// ----- sv/shared_mapping_tracker_table_top.sv -----
// A word with an invalid id goes straight to the finish state for its result;
// any other word walks all TABLE_ENTRIES slots, one memory read a cycle unless
// a revoke stalls, before its final result. A new word is taken only in idle,
// after the previous word's final result is pushed; the walk sets the pace.
// Revoke results leave as they are found, stalling the walk while the output is full.
// Reset clears the slot-used bits and control; the entry memory is not cleared.
module shared_mapping_tracker_table_top import smt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  action,
  input  logic [15:0] owner_id,
  input  logic [15:0] peer_id,
  input  logic [31:0] peer_virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [31:0] map_bytes,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [5:0]  slot_index,
  output logic        unmap_valid,
  output logic [15:0] unmap_peer,
  output logic [31:0] unmap_virt_addr,
  output logic [19:0] unmap_page_count,
  output logic [6:0]  cleared_count,
  output logic        last
);

  logic [IDX_W-1:0] raddr, waddr;
  logic             we, push, out_free;
  logic [ENTRY_W-1:0] rdata_raw, wdata_raw;
  entry_t           rdata, wdata;
  res_t             res, res_q;

  assign rdata     = entry_t'(rdata_raw);
  assign wdata_raw = wdata;

  smt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_raw),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  smt_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .action         (action),
    .owner_id       (owner_id),
    .peer_id        (peer_id),
    .peer_virt_addr (peer_virt_addr),
    .phys_addr      (phys_addr),
    .map_bytes      (map_bytes),
    .rdata          (rdata),
    .raddr          (raddr),
    .we             (we),
    .waddr          (waddr),
    .wdata          (wdata),
    .out_free       (out_free),
    .push           (push),
    .res            (res)
  );

  smt_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res       (res),
    .out_free  (out_free),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .res_q     (res_q)
  );

  assign status           = res_q.status;
  assign slot_index       = res_q.slot_index;
  assign unmap_valid      = res_q.unmap_valid;
  assign unmap_peer       = res_q.unmap_peer;
  assign unmap_virt_addr  = res_q.unmap_virt_addr;
  assign unmap_page_count = res_q.unmap_page_count;
  assign cleared_count    = res_q.cleared_count;
  assign last             = res_q.last;

endmodule
